[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the stem base-pair checker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, switched off during reset
`define SBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold out of reset
`define SBP_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SBP_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[sv/sbp_pkg.sv]
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types and constants for the stem base-pair checker.
// ----------------------------------------------------------------------------
package sbp_pkg;

    // Default stack depth / pair limit
    localparam int SBP_MAX_PAIRS = 16;

    // Field widths
    localparam int SYM_W    = 2;
    localparam int BASE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;
    localparam int COUNT_MAX = 15;

    // Pair sums
    localparam int PAIR_WC_SUM     = 3;
    localparam int PAIR_WOBBLE_SUM = 5;

    // Pattern symbol codes
    typedef enum logic [SYM_W-1:0] {
        SYM_OTHER = 2'd0,
        SYM_OPEN  = 2'd1,
        SYM_CLOSE = 2'd2,
        SYM_RSVD  = 2'd3
    } sym_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_UNBAL    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // Item handed from the stack-control stage to the pair-check stage
    typedef struct packed {
        logic                pop;        // stack read issued, check the pair
        logic [BASE_W-1:0]   base;       // closing base
        logic                last;       // final position of the pattern
        logic                unbal;      // unbalanced, final value at last
        logic                ovf;        // too many pairs, final value at last
        logic [COUNT_W-1:0]  count;      // saturated open count at last
    } chk_item_t;

endpackage

[sv/stem_base_pair_checker.sv]
// ----------------------------------------------------------------------------
// stem_base_pair_checker
// Dot-bracket stem checker: pairs open and close brackets through a base
// stack and reports a status and pair count per pattern.
// ----------------------------------------------------------------------------
// Use:
//   s_* carries one pattern position per beat: tdata[1:0] symbol
//   (0 other, 1 open, 2 close), tdata[3:2] base (A, C, G, T), tlast on
//   the final position. Only a beat with tlast gives a result beat.
//   m_* carries the result: tdata[1:0] status, tdata[5:2] pair_count.
//   cfg_we/cfg_wdata writes wobble_enable (G-T pairs allowed); write it
//   only while no pattern is in flight.
// Timing:
//   One position per cycle unless held by the stall below. The stack sits
//   in a RAM with a registered read; a close bracket reads the stack on
//   accept and the pair is checked in the following stage, and the
//   result beat is then registered in the output register.
// Reset / stall:
//   Reset clears the counters, flags, pipeline and wobble_enable; the stack
//   RAM is not cleared, as only written entries are ever read. While a
//   result beat waits on m_tready, positions are still taken until a
//   second result is ready, then s_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stem_base_pair_checker #(
    parameter int MAX_PAIRS = sbp_pkg::SBP_MAX_PAIRS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [1:0] symbol, [3:2] base
    input  logic       s_tlast,     // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [1:0] status, [5:2] pair_count
    input  logic       cfg_we,
    input  logic       cfg_wdata    // wobble_enable
);
    import sbp_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PAIRS);
    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);

    logic               wobble_reg;
    logic [CNT_W-1:0]   depth_reg;
    logic [CNT_W-1:0]   depth_next;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   total_next;
    logic               unbal_reg;
    logic               unbal_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               accept;
    logic               push;
    logic               pop;
    logic               unbal_fin;
    sym_t               symbol;
    logic [BASE_W-1:0]  base;
    logic [CNT_W-1:0]   depth_dec;
    logic [BASE_W-1:0]  top_base;
    chk_item_t          item;
    logic               chk_free;

    assign symbol    = sym_t'(s_tdata[SYM_W-1:0]);
    assign base      = s_tdata[SYM_W+BASE_W-1:SYM_W];
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = chk_free;
    assign depth_dec = depth_reg - CNT_W'(1);

    // Stack control for one position
    always_comb
    begin
        depth_next = depth_reg;
        total_next = total_reg;
        unbal_next = unbal_reg;
        ovf_next   = ovf_reg;
        push       = 1'b0;
        pop        = 1'b0;
        if (!ovf_reg)
        begin
            unique case (symbol)
                SYM_OPEN:
                begin
                    if (32'(total_reg) + 32'd1 >= 32'(MAX_PAIRS))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        push       = 1'b1;
                        depth_next = depth_reg + CNT_W'(1);
                        total_next = total_reg + CNT_W'(1);
                    end
                end
                SYM_CLOSE:
                begin
                    if (depth_reg == '0)
                    begin
                        unbal_next = 1'b1;
                    end
                    else
                    begin
                        pop        = 1'b1;
                        depth_next = depth_dec;
                    end
                end
                default:
                begin
                end
            endcase
        end
        unbal_fin = unbal_next || (!ovf_next && (depth_next != '0));
    end

    // Item for the pair-check stage
    always_comb
    begin
        item.pop   = pop;
        item.base  = base;
        item.last  = s_tlast;
        item.unbal = unbal_fin;
        item.ovf   = ovf_next;
        if (32'(total_next) > 32'(COUNT_MAX))
        begin
            item.count = COUNT_W'(COUNT_MAX);
        end
        else
        begin
            item.count = COUNT_W'(total_next);
        end
    end

    // Pattern state, cleared after the last position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            total_reg <= '0;
            unbal_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                depth_reg <= '0;
                total_reg <= '0;
                unbal_reg <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                depth_reg <= depth_next;
                total_reg <= total_next;
                unbal_reg <= unbal_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wobble_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            wobble_reg <= cfg_wdata;
        end
    end

    sbp_stack_mem #(
        .DEPTH  (MAX_PAIRS),
        .ADDR_W (ADDR_W)
    ) u_stack (
        .clk     (clk),
        .wr_en   (accept && push),
        .wr_addr (depth_reg[ADDR_W-1:0]),
        .wr_data (base),
        .rd_en   (accept && pop),
        .rd_addr (depth_dec[ADDR_W-1:0]),
        .rd_data (top_base)
    );

    sbp_pair_check u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .item     (item),
        .top_base (top_base),
        .wobble   (wobble_reg),
        .free     (chk_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Checks
    `SBP_NEVER(a_depth_le_total, clk, rst_n, depth_reg > total_reg, "stack deeper than open count")
    `SBP_NEVER(a_total_limit, clk, rst_n, 32'(total_reg) >= 32'(MAX_PAIRS), "open count reached limit")
    `SBP_ASSERT(a_clear_on_last, clk, rst_n, (accept && s_tlast) |=> (depth_reg == '0 && total_reg == '0 && !ovf_reg), "pattern state not cleared")
    `SBP_ASSERT(a_ovf_freeze, clk, rst_n, (accept && ovf_reg && !s_tlast) |=> $stable(depth_reg), "stack moved after overflow")

endmodule

[sv/sbp_stack_mem.sv]
// ----------------------------------------------------------------------------
// sbp_stack_mem
// Open-bracket base stack: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sbp_stack_mem #(
    parameter int DEPTH  = sbp_pkg::SBP_MAX_PAIRS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [sbp_pkg::BASE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [sbp_pkg::BASE_W-1:0] rd_data
);
    import sbp_pkg::*;

    logic [BASE_W-1:0] mem [DEPTH];
    logic [BASE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/sbp_pair_check.sv]
// ----------------------------------------------------------------------------
// sbp_pair_check
// Second stage: checks popped pairs, keeps the mismatch flag and holds the
// result beat in an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbp_pair_check (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,       // item accepted upstream
    input  sbp_pkg::chk_item_t         item,
    input  logic [sbp_pkg::BASE_W-1:0] top_base,   // popped base from the stack
    input  logic                       wobble,
    output logic                       free,       // stage can take an item
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata     // [1:0] status, [5:2] pair_count
);
    import sbp_pkg::*;

    logic                      s1_valid_reg;
    chk_item_t                 s1_item_reg;
    logic                      mismatch_reg;
    logic                      mismatch_next;
    logic                      out_valid_reg;
    logic [STATUS_W+COUNT_W-1:0] out_data_reg;
    logic                      advance;
    logic                      out_free;
    logic [BASE_W:0]           pair_sum;
    logic                      pair_bad;
    logic                      mismatch_fin;
    status_t                   status;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = s1_valid_reg && (!s1_item_reg.last || out_free);
    assign free     = !s1_valid_reg || advance;

    // Pair test on the popped base
    always_comb
    begin
        pair_sum = {1'b0, top_base} + {1'b0, s1_item_reg.base};
        pair_bad = s1_item_reg.pop
                   && (pair_sum != (BASE_W+1)'(PAIR_WC_SUM))
                   && !(wobble && (pair_sum == (BASE_W+1)'(PAIR_WOBBLE_SUM)));
        mismatch_fin = mismatch_reg || pair_bad;
        mismatch_next = s1_item_reg.last ? 1'b0 : mismatch_fin;
    end

    // Status priority: unbalanced, too many pairs, mismatch, ok
    always_comb
    begin
        priority if (s1_item_reg.unbal)
        begin
            status = ST_UNBAL;
        end
        else if (s1_item_reg.ovf)
        begin
            status = ST_OVERFLOW;
        end
        else if (mismatch_fin)
        begin
            status = ST_MISMATCH;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            mismatch_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                mismatch_reg <= mismatch_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_item_reg <= item;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && s1_item_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_item_reg.last)
        begin
            out_data_reg <= {s1_item_reg.count, status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - STATUS_W - COUNT_W){1'b0}}, out_data_reg};

    // Checks
    `SBP_ASSERT(a_stall_only_full, clk, rst_n, (s1_valid_reg && !advance) |-> (out_valid_reg && !m_tready), "pair stage stalled with output free")
    `SBP_NEVER(a_load_when_busy, clk, rst_n, load && !free, "item loaded into a busy pair stage")
    `SBP_ASSERT(a_mismatch_clear, clk, rst_n, (advance && s1_item_reg.last) |=> !mismatch_reg, "mismatch flag kept across patterns")

endmodule

[test/stem_base_pair_checker_tb.sv]
// ----------------------------------------------------------------------------
// stem_base_pair_checker_tb
// Self-checking bench for the dot-bracket stem checker. A short table of
// hand-picked positions comes first, then random patterns, mostly balanced
// with random bases and some broken or pure noise. Each accepted position
// drives a bit-true model of the pair stack. Result beats are compared field
// by field with the oldest predicted verdict. The sender and the receiver
// both idle at random.
// ----------------------------------------------------------------------------
module stem_base_pair_checker_tb;

    import sbp_pkg::*;

    localparam int PAIRS = SBP_MAX_PAIRS;

    // One pattern position as the sender sees it
    typedef struct {
        sym_t       sym;
        logic [1:0] base;
    } position_t;

    // Verdict for one pattern
    typedef struct {
        status_t    status;
        logic [3:0] pairs;
    } verdict_t;

    // Directed table row; the position is sent reps times
    typedef struct {
        sym_t       sym;
        logic [1:0] base;
        bit         last;
        int         reps;
        bit         typed;
        status_t    status;
        logic [3:0] pairs;
    } table_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;      // [1:0] symbol, [3:2] base, [7:4] zero
    logic       s_tlast;      // last
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;      // [1:0] status, [5:2] pair_count
    logic       cfg_we;
    logic       cfg_wdata;    // wobble_enable

    // Model of the pair stack
    logic [1:0] base_stack [PAIRS];
    int         stack_fill = 0;
    int         opens_taken = 0;
    bit         mismatch_flag = 1'b0;
    bit         unbal_flag = 1'b0;
    bit         ovf_flag = 1'b0;
    bit         wobble_on = 1'b0;

    verdict_t   verdict_q [$];
    int         fault_count = 0;
    int         items_sent = 0;
    int         gap_style = 0;
    int         ready_style = 0;
    int         stall_left = 0;

    table_row_t directed [] = '{
        '{SYM_OPEN,  2'd0, 1'b0, 1,  1'b0, ST_OK,       4'd0},
        '{SYM_CLOSE, 2'd3, 1'b1, 1,  1'b1, ST_OK,       4'd1},   // A-T
        '{SYM_OTHER, 2'd3, 1'b1, 1,  1'b1, ST_OK,       4'd0},   // empty pattern
        '{SYM_CLOSE, 2'd0, 1'b1, 1,  1'b1, ST_UNBAL,    4'd0},   // close on empty stack
        '{SYM_OPEN,  2'd2, 1'b0, 1,  1'b0, ST_OK,       4'd0},
        '{SYM_CLOSE, 2'd3, 1'b1, 1,  1'b1, ST_MISMATCH, 4'd1},   // G-T, wobble off
        '{SYM_OPEN,  2'd1, 1'b1, 1,  1'b1, ST_UNBAL,    4'd1},   // open left at end
        '{SYM_RSVD,  2'd2, 1'b1, 1,  1'b1, ST_OK,       4'd0},   // reserved symbol
        '{SYM_OPEN,  2'd1, 1'b0, 15, 1'b0, ST_OK,       4'd0},
        '{SYM_OPEN,  2'd3, 1'b0, 1,  1'b0, ST_OK,       4'd0},   // one open too many
        '{SYM_CLOSE, 2'd2, 1'b1, 1,  1'b1, ST_OVERFLOW, 4'd15}   // ignored after overflow
    };

    stem_base_pair_checker #(
        .MAX_PAIRS (PAIRS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one position to the stack model; returns 1 when a verdict is due
    function automatic bit score_position(input sym_t sym, input logic [1:0] base,
                                          input bit last, output verdict_t v);
        int sum;
        v = '{ST_OK, 4'd0};
        if (!ovf_flag)
        begin
            if (sym == SYM_OPEN)
            begin
                if (opens_taken + 1 >= PAIRS)
                    ovf_flag = 1'b1;
                else
                begin
                    if (stack_fill < PAIRS)
                    begin
                        base_stack[stack_fill] = base;
                        stack_fill++;
                    end
                    opens_taken++;
                end
            end
            else if (sym == SYM_CLOSE)
            begin
                if (stack_fill == 0)
                    unbal_flag = 1'b1;
                else
                begin
                    stack_fill--;
                    sum = int'(base_stack[stack_fill]) + int'(base);
                    if (sum != PAIR_WC_SUM && !(wobble_on && sum == PAIR_WOBBLE_SUM))
                        mismatch_flag = 1'b1;
                end
            end
        end
        if (!last)
            return 1'b0;
        if (!ovf_flag && stack_fill != 0)
            unbal_flag = 1'b1;
        if (unbal_flag)
            v.status = ST_UNBAL;
        else if (ovf_flag)
            v.status = ST_OVERFLOW;
        else if (mismatch_flag)
            v.status = ST_MISMATCH;
        else
            v.status = ST_OK;
        v.pairs = (opens_taken > COUNT_MAX) ? 4'(COUNT_MAX) : 4'(opens_taken);
        // next pattern starts clean; the register is kept
        stack_fill = 0;
        opens_taken = 0;
        mismatch_flag = 1'b0;
        unbal_flag = 1'b0;
        ovf_flag = 1'b0;
        return 1'b1;
    endfunction

    // Sender gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (gap_style == 1)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // Closing base: mostly the partner of the open base, sometimes anything
    function automatic logic [1:0] close_partner(input logic [1:0] ob);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 2'(PAIR_WC_SUM - int'(ob));
        else if (r < 80 && ob >= 2'd2)
            return 2'(PAIR_WOBBLE_SUM - int'(ob));
        else
            return 2'($urandom_range(0, 3));
    endfunction

    // Present one beat, wait for the handshake, record the verdict, then idle
    task automatic send_beat(input sym_t sym, input logic [1:0] base, input bit last,
                             input bit typed, input status_t st, input logic [3:0] pairs);
        verdict_t v;
        int       gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, base, sym};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (score_position(sym, base, last, v))
        begin
            if (typed)
                v = '{st, pairs};
            verdict_q.push_back(v);
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every verdict has been returned
    task automatic drain();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write, only called with the block idle
    task automatic write_wobble(input bit val);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        wobble_on = val;
    endtask

    // One random pattern: balanced, broken or noise
    task automatic send_pattern();
        position_t  seq [$];
        logic [1:0] open_q [$];
        int         close_idx [$];
        int         kind;
        int         r;
        int         opens_left;
        int         idx;
        logic [1:0] ob;
        kind = $urandom_range(0, 99);
        r = $urandom_range(0, 99);
        if (r < 85)
            opens_left = $urandom_range(0, 4);
        else if (r < 95)
            opens_left = $urandom_range(5, 12);
        else
            opens_left = $urandom_range(13, 17);
        if (kind >= 85)
        begin
            // noise: any symbol, any base
            repeat ($urandom_range(1, 10))
                seq.push_back('{sym_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3))});
        end
        else
        begin
            // balanced brackets with gaps between them
            while (opens_left > 0 || open_q.size() > 0)
            begin
                if ($urandom_range(0, 4) == 0)
                    seq.push_back('{SYM_OTHER, 2'($urandom_range(0, 3))});
                else if (opens_left > 0 && (open_q.size() == 0 || $urandom_range(0, 1) == 1))
                begin
                    ob = 2'($urandom_range(0, 3));
                    open_q.push_back(ob);
                    seq.push_back('{SYM_OPEN, ob});
                    opens_left--;
                end
                else
                begin
                    ob = open_q.pop_back();
                    seq.push_back('{SYM_CLOSE, close_partner(ob)});
                end
            end
            // broken: drop a close, add a stray close, or spoil a symbol
            if (kind >= 70)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        foreach (seq[i])
                            if (seq[i].sym == SYM_CLOSE)
                                close_idx.push_back(i);
                        if (close_idx.size() > 0)
                            seq.delete(close_idx[$urandom_range(0, close_idx.size() - 1)]);
                    end
                    1:
                        seq.push_front('{SYM_CLOSE, 2'($urandom_range(0, 3))});
                    default:
                        if (seq.size() > 0)
                        begin
                            idx = $urandom_range(0, seq.size() - 1);
                            seq[idx].sym = sym_t'($urandom_range(0, 3));
                        end
                endcase
            end
        end
        if (seq.size() == 0)
            seq.push_back('{SYM_OTHER, 2'($urandom_range(0, 3))});
        foreach (seq[i])
            send_beat(seq[i].sym, seq[i].base, i == seq.size() - 1, 1'b0, ST_OK, 4'd0);
    endtask

    // Receiver: random stalls, mostly short, a few long
    always @(posedge clk)
    begin
        int r;
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (ready_style != 1 && $urandom_range(0, 99) < 20)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                stall_left = $urandom_range(0, 1);
            else if (r < 95)
                stall_left = $urandom_range(2, 7);
            else
                stall_left = $urandom_range(14, 39);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Result beat check against the oldest verdict
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result beat: status %0d pairs %0d",
                             m_tdata[1:0], m_tdata[5:2]);
            end
            else
            begin
                exp_v = verdict_q.pop_front();
                if (m_tdata[1:0] !== exp_v.status || m_tdata[5:2] !== exp_v.pairs)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("result mismatch: status exp %0d got %0d, pairs exp %0d got %0d",
                                 exp_v.status, m_tdata[1:0], exp_v.pairs, m_tdata[5:2]);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int  ph;
        int  target;
        bit  wob;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        m_tready  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, wobble at its reset value
        foreach (directed[i])
            repeat (directed[i].reps)
                send_beat(directed[i].sym, directed[i].base, directed[i].last,
                          directed[i].typed, directed[i].status, directed[i].pairs);

        // random phases, each with its own wobble setting and idling style
        for (ph = 0; ph < 8; ph++)
        begin
            drain();
            if (ph == 0)
                wob = 1'b1;
            else if (ph == 1)
                wob = 1'b0;
            else
                wob = 1'($urandom_range(0, 1));
            write_wobble(wob);
            gap_style = ph % 3;
            ready_style = (ph % 3 == 1) ? 1 : 0;
            target = items_sent + 128;
            while (items_sent < target)
            begin
                send_pattern();
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fault_count == 0 && verdict_q.size() == 0)
            $display("stem_base_pair_checker regression: pass");
        else
            $display("stem_base_pair_checker regression: fail");
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("stem_base_pair_checker regression: fail");
        $finish;
    end

endmodule
